>>> hw/rtl/stxetx_pkg.sv
// Shared types, codes and constants for the STX/ETX message deframer.
package stxetx_pkg;

    localparam int DEF_BUFFER_DEPTH = 32;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 6;
    localparam int CFG_IDX_W = 1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_RX   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

    // Buffer states
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FILLING = 2'd1;
    localparam logic [STAT_W-1:0] ST_VALID   = 2'd2;

    // Input commands
    localparam logic CMD_RECEIVE = 1'b0;
    localparam logic CMD_FETCH   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 1'b1;

    localparam logic [BYTE_W-1:0] START_CODE_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'h03;

    typedef struct packed {
        logic rx;           // process a received byte
        logic fetch_start;  // latch the message and read its first byte
        logic fetch_none;   // report that no message is ready
        logic stream_load;  // load the next message byte into the result register
    } cmd_t;

    typedef struct packed {
        logic msg_ready;
        logic last_byte;
    } sts_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] buffer_status;
        logic              message_complete;
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
        logic [LEN_W-1:0]  stored_length;
    } res_t;

endpackage

>>> hw/rtl/stxetx_in_if.sv
// Input channel: received bytes and fetch commands.
interface stxetx_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;
    logic       rx_error;

    modport source (output valid, command, rx_byte, rx_error, input ready);
    modport sink   (input valid, command, rx_byte, rx_error, output ready);
endinterface

>>> hw/rtl/stxetx_out_if.sv
// Result channel: receive reports, message bytes and no-message answers.
interface stxetx_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [1:0] buffer_status;
    logic       message_complete;
    logic [7:0] out_byte;
    logic       out_last;
    logic [5:0] stored_length;

    modport source (output valid, kind, buffer_status, message_complete, out_byte,
                    out_last, stored_length, input ready);
    modport sink   (input valid, kind, buffer_status, message_complete, out_byte,
                    out_last, stored_length, output ready);
endinterface

>>> hw/rtl/stxetx_ctrl.sv
// Controller state machine: input/output handshakes and message streaming.
module stxetx_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_command,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  stxetx_pkg::sts_t    sts,
    output stxetx_pkg::cmd_t    cmd
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_STREAM = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic can_load;
    logic in_acc;

    assign can_load  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && can_load;
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_command == stxetx_pkg::CMD_RECEIVE)
                    begin
                        cmd.rx = 1'b1;
                    end
                    else if (sts.msg_ready)
                    begin
                        cmd.fetch_start = 1'b1;
                        state_next      = S_STREAM;
                    end
                    else
                    begin
                        cmd.fetch_none = 1'b1;
                    end
                end
            end
            S_STREAM:
            begin
                if (can_load)
                begin
                    cmd.stream_load = 1'b1;
                    if (sts.last_byte)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold a stalled result; set when any result is loaded.
    assign out_valid_next = (out_valid_reg && !out_ready) || cmd.rx || cmd.fetch_none
                            || cmd.stream_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/stxetx_dp.sv
// Datapath: code registers, buffer state, message store and result register.
module stxetx_dp #(
    parameter int BUFFER_DEPTH = stxetx_pkg::DEF_BUFFER_DEPTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [stxetx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stxetx_pkg::BYTE_W-1:0]        cfg_wdata,
    input  logic [stxetx_pkg::BYTE_W-1:0]        rx_byte,
    input  logic                                 rx_error,
    input  stxetx_pkg::cmd_t                     cmd,
    output stxetx_pkg::sts_t                     sts,
    output stxetx_pkg::res_t                     res
);

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [stxetx_pkg::BYTE_W-1:0] start_code_reg;
    logic [stxetx_pkg::BYTE_W-1:0] end_code_reg;
    logic [stxetx_pkg::STAT_W-1:0] state_reg;
    logic [stxetx_pkg::STAT_W-1:0] state_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [CNT_W-1:0]              len_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [stxetx_pkg::BYTE_W-1:0] rd_data_reg;
    stxetx_pkg::res_t              res_reg;

    logic [stxetx_pkg::BYTE_W-1:0] store_mem [BUFFER_DEPTH];

    logic             complete;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             last_byte;

    // Receive decode
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        complete   = 1'b0;
        wr_en      = 1'b0;
        if (!rx_error)
        begin
            if (rx_byte == start_code_reg)
            begin
                if (state_reg != stxetx_pkg::ST_VALID)
                begin
                    count_next = '0;
                    state_next = stxetx_pkg::ST_FILLING;
                end
            end
            else if (rx_byte == end_code_reg)
            begin
                if (state_reg == stxetx_pkg::ST_FILLING && count_reg != '0)
                begin
                    state_next = stxetx_pkg::ST_VALID;
                    complete   = 1'b1;
                end
            end
            else if (state_reg == stxetx_pkg::ST_FILLING
                     && count_reg < CNT_W'(BUFFER_DEPTH))
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    assign last_byte = (CNT_W'(idx_reg) + CNT_W'(1)) == len_reg;
    assign rd_en     = cmd.fetch_start || (cmd.stream_load && !last_byte);
    assign rd_addr   = cmd.fetch_start ? '0 : idx_reg + IDX_W'(1);

    assign sts.msg_ready = (state_reg == stxetx_pkg::ST_VALID) && (count_reg != '0);
    assign sts.last_byte = last_byte;
    assign res           = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= stxetx_pkg::START_CODE_RST;
            end_code_reg   <= stxetx_pkg::END_CODE_RST;
            state_reg      <= stxetx_pkg::ST_EMPTY;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    stxetx_pkg::CFG_START_CODE: start_code_reg <= cfg_wdata;
                    stxetx_pkg::CFG_END_CODE:   end_code_reg   <= cfg_wdata;
                    default:                    ;
                endcase
            end
            if (cmd.rx)
            begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
            else if (cmd.fetch_start)
            begin
                state_reg <= stxetx_pkg::ST_EMPTY;
                count_reg <= '0;
            end
        end
    end

    // Message store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.rx && wr_en)
        begin
            store_mem[count_reg[IDX_W-1:0]] <= rx_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch_start)
        begin
            len_reg <= count_reg;
            idx_reg <= '0;
        end
        else if (cmd.stream_load && !last_byte)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end

        if (cmd.rx)
        begin
            res_reg.kind             <= stxetx_pkg::KIND_RX;
            res_reg.buffer_status    <= state_next;
            res_reg.message_complete <= complete;
            res_reg.out_byte         <= '0;
            res_reg.out_last         <= 1'b1;
            res_reg.stored_length    <= stxetx_pkg::LEN_W'(count_next);
        end
        else if (cmd.fetch_none)
        begin
            res_reg.kind             <= stxetx_pkg::KIND_NONE;
            res_reg.buffer_status    <= state_reg;
            res_reg.message_complete <= 1'b0;
            res_reg.out_byte         <= '0;
            res_reg.out_last         <= 1'b1;
            res_reg.stored_length    <= stxetx_pkg::LEN_W'(count_reg);
        end
        else if (cmd.stream_load)
        begin
            res_reg.kind             <= stxetx_pkg::KIND_BYTE;
            res_reg.buffer_status    <= stxetx_pkg::ST_EMPTY;
            res_reg.message_complete <= 1'b0;
            res_reg.out_byte         <= rd_data_reg;
            res_reg.out_last         <= last_byte;
            res_reg.stored_length    <= stxetx_pkg::LEN_W'(len_reg);
        end
    end

endmodule

>>> hw/rtl/uart_stx_etx_message_deframer_top.sv
// Top level of the STX/ETX message deframer.
//
// req carries one item per transfer: a received UART byte with its error flag
// (command 0) or a fetch of the stored message (command 1). rsp carries results.
// A received byte gives one receive report in the cycle after its transfer.
// A fetch of a valid message gives its N stored bytes, one per cycle while
// rsp.ready is high, with out_last on the final byte; each byte passes the
// store's single registered read port and then the result register.
// A fetch with no message ready gives one answer in the next cycle.
// Receive items can follow each other every cycle while rsp.ready is high;
// req.ready stays low while a message streams out.
// A result waits in the output register while rsp.ready is low; req can still
// transfer one item into that slot as the waiting result leaves, and streaming
// pauses until the stalled byte is taken.
// Reset empties the buffer, zeroes the fill count and restores start code 0x02
// and end code 0x03; the store contents are not cleared and need no sweep.
// Write cfg_wdata to register cfg_index (0 start code, 1 end code) only while idle.
module uart_stx_etx_message_deframer_top #(
    parameter int BUFFER_DEPTH = stxetx_pkg::DEF_BUFFER_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [stxetx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [stxetx_pkg::BYTE_W-1:0]    cfg_wdata,
    stxetx_in_if.sink                        req,
    stxetx_out_if.source                     rsp
);

    stxetx_pkg::cmd_t cmd;
    stxetx_pkg::sts_t sts;
    stxetx_pkg::res_t res;

    stxetx_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_command (req.command),
        .in_ready   (req.ready),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    stxetx_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rx_byte   (req.rx_byte),
        .rx_error  (req.rx_error),
        .cmd       (cmd),
        .sts       (sts),
        .res       (res)
    );

    assign rsp.kind             = res.kind;
    assign rsp.buffer_status    = res.buffer_status;
    assign rsp.message_complete = res.message_complete;
    assign rsp.out_byte         = res.out_byte;
    assign rsp.out_last         = res.out_last;
    assign rsp.stored_length    = res.stored_length;

endmodule

>>> hw/rtl/stxetx_chk.sv
// Port-level checker for the deframer top level, with its bind statement.
module stxetx_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_command,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] kind,
    input logic [1:0] buffer_status,
    input logic       message_complete,
    input logic       out_last
);

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A receive transfer is reported in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_command == stxetx_pkg::CMD_RECEIVE
        |=> out_valid && kind == stxetx_pkg::KIND_RX && out_last)
        else $error("receive report missing");

    // No new item while a message is still streaming.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == stxetx_pkg::KIND_BYTE && !out_last
        |-> !in_ready)
        else $error("input taken during message stream");

    // A completed message leaves the buffer valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_complete
        |-> kind == stxetx_pkg::KIND_RX && buffer_status == stxetx_pkg::ST_VALID)
        else $error("completion without valid buffer");

endmodule

bind uart_stx_etx_message_deframer_top stxetx_chk u_stxetx_chk
(
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (req.valid),
    .in_ready         (req.ready),
    .in_command       (req.command),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .kind             (rsp.kind),
    .buffer_status    (rsp.buffer_status),
    .message_complete (rsp.message_complete),
    .out_last         (rsp.out_last)
);

>>> verif/deframer_monitor.sv
// Channel monitor for the deframer: predicts every result and compares each transfer on rsp.
`timescale 1ns / 1ps

module deframer_monitor
    import stxetx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,
    stxetx_in_if                 req,
    stxetx_out_if                rsp,
    output int                   mismatches,
    output int                   awaiting
);

    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
    logic [STAT_W-1:0] frame_state;
    logic [6:0]        fill_count;
    logic [BYTE_W-1:0] frame_bytes [DEF_BUFFER_DEPTH];
    res_t              awaited_results [$];
    res_t              want;

    function automatic res_t make_result(logic [KIND_W-1:0] kind, logic [STAT_W-1:0] status,
                                         logic complete, logic [BYTE_W-1:0] data,
                                         logic last, logic [6:0] len);
        res_t r;
        r.kind             = kind;
        r.buffer_status    = status;
        r.message_complete = complete;
        r.out_byte         = data;
        r.out_last         = last;
        r.stored_length    = len[LEN_W-1:0];
        return r;
    endfunction

    // Advance the deframer state by one accepted item and queue what it should produce.
    task automatic deframe_item(input logic cmd, input logic [BYTE_W-1:0] b, input logic err);
        logic       complete;
        logic [6:0] n;
        int         i;
        complete = 1'b0;
        if (cmd == CMD_RECEIVE)
        begin
            if (!err)
            begin
                // start code wins when both codes are equal
                if (b == start_code)
                begin
                    if (frame_state != ST_VALID)
                    begin
                        fill_count  = '0;
                        frame_state = ST_FILLING;
                    end
                end
                else if (b == end_code)
                begin
                    if (frame_state == ST_FILLING && fill_count != 0)
                    begin
                        frame_state = ST_VALID;
                        complete    = 1'b1;
                    end
                end
                else if (frame_state == ST_FILLING && fill_count < DEF_BUFFER_DEPTH)
                begin
                    frame_bytes[fill_count] = b;
                    fill_count++;
                end
            end
            awaited_results.push_back(make_result(KIND_RX, frame_state, complete, '0, 1'b1,
                                                  fill_count));
        end
        else if (frame_state == ST_VALID && fill_count != 0)
        begin
            n = fill_count;
            for (i = 0; i < n; i++)
            begin
                awaited_results.push_back(make_result(KIND_BYTE, ST_EMPTY, 1'b0, frame_bytes[i],
                                                      (i == n - 1), n));
            end
            frame_state = ST_EMPTY;
            fill_count  = '0;
        end
        else
        begin
            awaited_results.push_back(make_result(KIND_NONE, frame_state, 1'b0, '0, 1'b1,
                                                  fill_count));
        end
    endtask

    task automatic compare_field(input string fname, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_val,
                     act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code  = START_CODE_RST;
            end_code    = END_CODE_RST;
            frame_state = ST_EMPTY;
            fill_count  = '0;
            awaited_results.delete();
            mismatches  = 0;
            awaiting   <= 0;
        end
        else
        begin
            // the result leaving now belongs to an earlier item, so check before predicting
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                             $time, rsp.kind, rsp.out_byte);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("kind", want.kind, rsp.kind);
                    compare_field("buffer_status", want.buffer_status, rsp.buffer_status);
                    compare_field("message_complete", want.message_complete,
                                  rsp.message_complete);
                    compare_field("out_byte", want.out_byte, rsp.out_byte);
                    compare_field("out_last", want.out_last, rsp.out_last);
                    compare_field("stored_length", want.stored_length, rsp.stored_length);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_START_CODE)
                    start_code = cfg_wdata;
                else if (cfg_index == CFG_END_CODE)
                    end_code = cfg_wdata;
            end
            if (req.valid && req.ready)
                deframe_item(req.command, req.rx_byte, req.rx_error);
            awaiting <= awaited_results.size();
        end
    end

endmodule

>>> verif/testbench.sv
// Testbench top for the deframer: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 1ps

module testbench;
    import stxetx_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_wdata;

    int                   mismatches;
    int                   awaiting;

    logic [BYTE_W-1:0]    cur_start;
    logic [BYTE_W-1:0]    cur_end;
    int                   gap_pct;
    int                   stall_pct;
    bit                   calm;
    int                   phase;
    logic [BYTE_W-1:0]    pick_a;
    logic [BYTE_W-1:0]    pick_b;

    stxetx_in_if  req();
    stxetx_out_if rsp();

    uart_stx_etx_message_deframer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    deframer_monitor mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .req        (req),
        .rsp        (rsp),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: stall in random bursts, never once the calm phase starts.
    initial
    begin
        rsp.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!calm && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Present one item and hold it until the transfer.
    task automatic send(input logic cmd, input logic [BYTE_W-1:0] b, input logic err);
        if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.command  <= cmd;
        req.rx_byte  <= b;
        req.rx_error <= err;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Hold off the sender until every predicted result has been taken.
    task automatic drain();
        int guard;
        guard = 0;
        req.valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_codes(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_CODE;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_index <= CFG_END_CODE;
        cfg_wdata <= e;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        cur_start = s;
        cur_end   = e;
    endtask

    task automatic send_frame(input int n, input bit noisy, input bit fetch_it);
        int i;
        send(CMD_RECEIVE, cur_start, 1'b0);
        for (i = 0; i < n; i++)
            send(CMD_RECEIVE, BYTE_W'($urandom), noisy && ($urandom_range(0, 7) == 0));
        send(CMD_RECEIVE, cur_end, 1'b0);
        if (fetch_it)
            send(CMD_FETCH, BYTE_W'($urandom), 1'($urandom));
    endtask

    task automatic random_traffic(input int target);
        int done_items;
        int r;
        int n;
        int i;
        done_items = 0;
        while (done_items < target)
        begin
            case ($urandom_range(0, 3))
                0: gap_pct = 0;
                1: gap_pct = 5;
                2: gap_pct = 15;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 5;
                2: stall_pct = 15;
                default: stall_pct = 40;
            endcase
            r = $urandom_range(0, 9);
            if (r < 6)
            begin
                // mostly short frames, a few empty ones and a few that overflow the store
                n = $urandom_range(0, 19);
                if (n < 2)
                    n = $urandom_range(30, 40);
                else if (n < 4)
                    n = 0;
                else
                    n = $urandom_range(1, 6);
                send_frame(n, $urandom_range(0, 3) == 0, $urandom_range(0, 9) != 0);
                done_items += n + 3;
            end
            else if (r < 8)
            begin
                for (i = 0; i < $urandom_range(1, 3); i++)
                    send(($urandom_range(0, 4) == 0) ? CMD_FETCH : CMD_RECEIVE,
                         BYTE_W'($urandom), $urandom_range(0, 3) == 0);
            end
            else if (r == 8)
            begin
                // broken frame: no end code, then a fetch or a fresh start
                n = $urandom_range(1, 4);
                send(CMD_RECEIVE, cur_start, 1'b0);
                for (i = 0; i < n; i++)
                    send(CMD_RECEIVE, BYTE_W'($urandom), 1'b0);
                if ($urandom_range(0, 1) == 0)
                    send(CMD_FETCH, BYTE_W'($urandom), 1'($urandom));
                else
                    send(CMD_RECEIVE, cur_start, 1'b0);
                done_items += n + 2;
            end
            else
            begin
                drain();
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_START_CODE;
        cfg_wdata    = '0;
        req.valid    = 1'b0;
        req.command  = CMD_RECEIVE;
        req.rx_byte  = '0;
        req.rx_error = 1'b0;
        cur_start    = START_CODE_RST;
        cur_end      = END_CODE_RST;
        gap_pct      = 20;
        stall_pct    = 20;
        calm         = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset codes
        send(CMD_FETCH, 8'h00, 1'b0);             // nothing stored yet
        send(CMD_RECEIVE, cur_end, 1'b0);         // end code while empty
        send(CMD_RECEIVE, 8'h41, 1'b0);           // data while empty
        send(CMD_RECEIVE, cur_start, 1'b0);
        send(CMD_RECEIVE, cur_end, 1'b0);         // end code with no data
        send(CMD_FETCH, 8'hFF, 1'b1);             // fetch while filling
        send(CMD_RECEIVE, 8'h00, 1'b0);
        send(CMD_RECEIVE, 8'hFF, 1'b0);
        send(CMD_RECEIVE, 8'h55, 1'b1);           // errored data byte
        send(CMD_RECEIVE, cur_start, 1'b1);       // errored start code
        send(CMD_RECEIVE, cur_start, 1'b0);       // restart while filling
        send(CMD_RECEIVE, 8'h80, 1'b0);
        send(CMD_RECEIVE, 8'h18, 1'b0);
        send(CMD_RECEIVE, cur_end, 1'b1);         // errored end code
        send(CMD_RECEIVE, cur_end, 1'b0);         // completes the message
        send(CMD_RECEIVE, cur_start, 1'b0);       // start code while valid
        send(CMD_RECEIVE, 8'h11, 1'b0);           // data while valid
        send(CMD_RECEIVE, cur_end, 1'b0);         // end code while valid
        send(CMD_FETCH, 8'hA5, 1'b0);
        send(CMD_FETCH, 8'h5A, 1'b1);             // already drained

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_codes(8'h00, 8'hFF);
                1: set_codes(8'hFF, 8'h00);
                2: set_codes(8'h80, 8'h80);       // equal codes
                default:
                begin
                    pick_a = BYTE_W'($urandom);
                    pick_b = BYTE_W'($urandom);
                    while (pick_b == pick_a)
                        pick_b = BYTE_W'($urandom);
                    set_codes(pick_a, pick_b);
                end
            endcase
            if (phase == 4)
                calm = 1'b1;
            random_traffic(22);
        end

        drain();
        if (mismatches == 0 && awaiting == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            if (awaiting != 0)
                $display("%0t: %0d expected results never arrived", $time, awaiting);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/stxetx_pkg.sv
hw/rtl/stxetx_in_if.sv
hw/rtl/stxetx_out_if.sv
hw/rtl/stxetx_ctrl.sv
hw/rtl/stxetx_dp.sv
hw/rtl/uart_stx_etx_message_deframer_top.sv
hw/rtl/stxetx_chk.sv
verif/deframer_monitor.sv
verif/testbench.sv
